@@ sv/websocket_frame_deframer_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the frame deframer
// Clocked, reset-qualified property checks used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Antecedent implies consequent (the consequent may start with a ## delay).
`define WSFD_ASSERT_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> cons) \
    else $error(msg);

// Condition holds at every clock edge outside reset.
`define WSFD_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) \
    else $error(msg);

`endif

@@ sv/wsfd_pkg.sv @@
// ---------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the frame deframer.
// ---------------------------------------------------------------------------
package wsfd_pkg;

  localparam int LEN_BITS_DEFAULT    = 64;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int BYTE_BITS = 8;
  localparam int USER_BITS = 6;

  localparam int FIN_BIT  = 7;
  localparam int MASK_BIT = 7;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // One classified result on its way to the output stage.
  typedef struct packed {
    logic [7:0] raw_byte;
    logic [7:0] key_byte;
    logic       present;
    logic       last;
    logic       fin;
    logic [3:0] opcode;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ sv/wsfd_front.sv @@
// ---------------------------------------------------------------------------
// wsfd_front
// Header parser: takes stream bytes, tracks frame phase and length, and
// pushes one classified result per payload byte or empty frame.
// ---------------------------------------------------------------------------
module wsfd_front #(
  parameter int LEN_BITS = wsfd_pkg::LEN_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  wsfd_pkg::q_status_t q_status,
  output logic                push,
  output wsfd_pkg::item_t     push_item
);

  wsfd_pkg::phase_t      phase, phase_next;
  logic [3:0]            ext_count, ext_count_next;
  logic [LEN_BITS-1:0]   remaining, remaining_next;
  logic [31:0]           mask_key, mask_key_next;
  logic [1:0]            mask_index, mask_index_next;
  logic                  is_masked, is_masked_next;
  logic                  fin_held, fin_held_next;
  logic [3:0]            opcode_held, opcode_held_next;

  logic       accept;
  logic [6:0] len_code;
  logic [7:0] key_byte;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign len_code = in_byte[6:0];

  always_comb begin
    case (mask_index)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wsfd_pkg::PH_HDR0;
      ext_count  <= 4'd0;
      mask_index <= 2'd0;
    end else begin
      phase      <= phase_next;
      ext_count  <= ext_count_next;
      mask_index <= mask_index_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining   <= remaining_next;
    mask_key    <= mask_key_next;
    is_masked   <= is_masked_next;
    fin_held    <= fin_held_next;
    opcode_held <= opcode_held_next;
  end

  always_comb begin
    phase_next       = phase;
    ext_count_next   = ext_count;
    remaining_next   = remaining;
    mask_key_next    = mask_key;
    mask_index_next  = mask_index;
    is_masked_next   = is_masked;
    fin_held_next    = fin_held;
    opcode_held_next = opcode_held;
    push             = 1'b0;
    // Default item is the empty-frame marker.
    push_item.raw_byte = 8'd0;
    push_item.key_byte = 8'd0;
    push_item.present  = 1'b0;
    push_item.last     = 1'b1;
    push_item.fin      = fin_held;
    push_item.opcode   = opcode_held;

    if (accept) begin
      case (phase)
        wsfd_pkg::PH_HDR0: begin
          fin_held_next    = in_byte[wsfd_pkg::FIN_BIT];
          opcode_held_next = in_byte[3:0];
          phase_next       = wsfd_pkg::PH_HDR1;
        end
        wsfd_pkg::PH_HDR1: begin
          is_masked_next = in_byte[wsfd_pkg::MASK_BIT];
          mask_key_next  = 32'd0;
          remaining_next = '0;
          if (len_code == wsfd_pkg::LEN_CODE_16) begin
            ext_count_next = wsfd_pkg::EXT_BYTES_16;
            phase_next     = wsfd_pkg::PH_EXT;
          end else if (len_code == wsfd_pkg::LEN_CODE_64) begin
            ext_count_next = wsfd_pkg::EXT_BYTES_64;
            phase_next     = wsfd_pkg::PH_EXT;
          end else begin
            remaining_next = LEN_BITS'(len_code);
            if (in_byte[wsfd_pkg::MASK_BIT]) begin
              ext_count_next = wsfd_pkg::KEY_BYTES;
              phase_next     = wsfd_pkg::PH_KEY;
            end else begin
              ext_count_next  = 4'd0;
              mask_index_next = 2'd0;
              if (len_code == 7'd0) begin
                push       = 1'b1;
                phase_next = wsfd_pkg::PH_HDR0;
              end else begin
                phase_next = wsfd_pkg::PH_DATA;
              end
            end
          end
        end
        wsfd_pkg::PH_EXT: begin
          // Shift in big-endian length; high bits beyond LEN_BITS drop off.
          remaining_next = {remaining[LEN_BITS-9:0], in_byte};
          ext_count_next = ext_count - 4'd1;
          if (ext_count_next == 4'd0) begin
            if (is_masked) begin
              ext_count_next = wsfd_pkg::KEY_BYTES;
              phase_next     = wsfd_pkg::PH_KEY;
            end else begin
              mask_index_next = 2'd0;
              if (remaining_next == '0) begin
                push       = 1'b1;
                phase_next = wsfd_pkg::PH_HDR0;
              end else begin
                phase_next = wsfd_pkg::PH_DATA;
              end
            end
          end
        end
        wsfd_pkg::PH_KEY: begin
          mask_key_next  = {mask_key[23:0], in_byte};
          ext_count_next = ext_count - 4'd1;
          if (ext_count_next == 4'd0) begin
            mask_index_next = 2'd0;
            if (remaining == '0) begin
              push       = 1'b1;
              phase_next = wsfd_pkg::PH_HDR0;
            end else begin
              phase_next = wsfd_pkg::PH_DATA;
            end
          end
        end
        wsfd_pkg::PH_DATA: begin
          push               = 1'b1;
          push_item.raw_byte = in_byte;
          push_item.key_byte = key_byte;
          push_item.present  = 1'b1;
          push_item.last     = (remaining == LEN_BITS'(1));
          remaining_next     = remaining - LEN_BITS'(1);
          mask_index_next    = mask_index + 2'd1;
          if (remaining == LEN_BITS'(1)) begin
            phase_next = wsfd_pkg::PH_HDR0;
          end
        end
        default: begin
          phase_next = wsfd_pkg::PH_HDR0;
        end
      endcase
    end
  end

endmodule

@@ sv/wsfd_queue.sv @@
// ---------------------------------------------------------------------------
// wsfd_queue
// Short register queue between the parser and the output stage.
// ---------------------------------------------------------------------------
module wsfd_queue #(
  parameter int DEPTH = wsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wsfd_pkg::item_t     push_item,
  input  logic                pop,
  output wsfd_pkg::item_t     head_item,
  output wsfd_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  wsfd_pkg::item_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_item    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ sv/wsfd_back.sv @@
// ---------------------------------------------------------------------------
// wsfd_back
// Output stage: unmasks the payload byte and holds the result in a
// register until the downstream side takes it.
// ---------------------------------------------------------------------------
module wsfd_back (
  input  logic                clk,
  input  logic                rst,
  input  wsfd_pkg::q_status_t q_status,
  input  wsfd_pkg::item_t     head_item,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // data_byte
  output logic                m_axis_tlast,  // last
  output logic [wsfd_pkg::USER_BITS-1:0] m_axis_tuser  // byte_present, frame_fin, frame_opcode
);

  assign pop = !q_status.empty && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= head_item.raw_byte ^ head_item.key_byte;
      m_axis_tlast <= head_item.last;
      m_axis_tuser <= {head_item.opcode, head_item.fin, head_item.present};
    end
  end

endmodule

@@ sv/websocket_frame_deframer_core.sv @@
// An accepted byte's result is written into the result queue and then moved
//   into the output register, where it is held until taken.
// Throughput: 1 byte per cycle while the result queue is not full, set by the
//   LEN_BITS-wide remaining-length decrement and compare.
// Header bytes produce no result except the empty-frame marker; the output stage may stall without losing input.
// Reset: synchronous, active high; clears parser phase, queue and output valid.
// ---------------------------------------------------------------------------
// websocket_frame_deframer_core
// Frame deframer top level: parser front, result queue, output stage.
// ---------------------------------------------------------------------------
`include "websocket_frame_deframer_core_assert.svh"

module websocket_frame_deframer_core #(
  parameter int LEN_BITS    = wsfd_pkg::LEN_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = wsfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // data_byte
  output logic       m_axis_tlast,   // last
  output logic [wsfd_pkg::USER_BITS-1:0] m_axis_tuser  // byte_present, frame_fin, frame_opcode
);

  wsfd_pkg::q_status_t q_status;
  wsfd_pkg::item_t     push_item;
  wsfd_pkg::item_t     head_item;
  logic                push;
  logic                pop;

  wsfd_front #(
    .LEN_BITS (LEN_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  wsfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .status    (q_status)
  );

  wsfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .head_item     (head_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // An empty-frame marker carries no byte and always closes its frame.
  `WSFD_ASSERT_ALWAYS(a_marker_shape, clk, rst,
    !m_axis_tvalid || m_axis_tuser[0] || (m_axis_tlast && m_axis_tdata == 8'd0),
    "empty-frame marker malformed")
  // The queue only fills while the output stage is stalled.
  `WSFD_ASSERT_ALWAYS(a_full_implies_out_busy, clk, rst, s_axis_tready || m_axis_tvalid,
    "input stalled with idle output")
  // A result pushed into an empty queue with a free output passes through the queue and reaches the output register.
  `WSFD_ASSERT_IMPLIES(a_push_reaches_out, clk, rst,
    push && q_status.empty && (!m_axis_tvalid || m_axis_tready), ##2 m_axis_tvalid,
    "pushed result did not reach output")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Frame deframer testbench
// Streams WebSocket frames byte by byte into the deframer with random gaps
// and output stalls, predicts each unmasked payload byte and empty-frame
// marker, and compares every result as it leaves the block.
// ---------------------------------------------------------------------------
module testbench;

  localparam int TARGET_BYTES = 1300;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
    logic       fin;
    logic [3:0] opcode;
  } deframed_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;    // in_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;    // data_byte
  logic       m_axis_tlast;    // last
  logic [wsfd_pkg::USER_BITS-1:0] m_axis_tuser;  // byte_present, frame_fin, frame_opcode[3:0]

  // parser state mirrored by the predictor
  wsfd_pkg::phase_t parse_phase;
  logic [3:0]  hdr_left;
  logic [63:0] bytes_left;
  logic [31:0] key_word;
  logic [1:0]  key_pos;
  logic        masked_frame;
  logic        fin_bit;
  logic [3:0]  opcode_nib;

  logic [7:0] wire_bytes[$];
  deframed_t  deframed_q[$];

  int unsigned cycle_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned markers_predicted = 0;
  int unsigned frames_built = 0;
  int unsigned mismatches = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  logic        hold_off;

  websocket_frame_deframer_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void add_wire_byte(input logic [7:0] b);
    wire_bytes.insert(wire_bytes.size(), b);
  endfunction

  function automatic void add_expected(input deframed_t r);
    deframed_q.insert(deframed_q.size(), r);
  endfunction

  // Header complete: enter the payload, or emit the empty-frame marker.
  function automatic void close_header();
    deframed_t r;
    key_pos = '0;
    if (bytes_left == 64'd0) begin
      r.data    = 8'h00;
      r.present = 1'b0;
      r.last    = 1'b1;
      r.fin     = fin_bit;
      r.opcode  = opcode_nib;
      add_expected(r);
      markers_predicted++;
      parse_phase = wsfd_pkg::PH_HDR0;
    end else begin
      parse_phase = wsfd_pkg::PH_DATA;
    end
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    deframed_t  r;
    logic [7:0] kb;
    case (parse_phase)
      wsfd_pkg::PH_HDR0: begin
        fin_bit     = b[wsfd_pkg::FIN_BIT];
        opcode_nib  = b[3:0];
        parse_phase = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_HDR1: begin
        masked_frame = b[wsfd_pkg::MASK_BIT];
        key_word     = '0;
        bytes_left   = '0;
        if (b[6:0] == wsfd_pkg::LEN_CODE_16) begin
          hdr_left    = wsfd_pkg::EXT_BYTES_16;
          parse_phase = wsfd_pkg::PH_EXT;
        end else if (b[6:0] == wsfd_pkg::LEN_CODE_64) begin
          hdr_left    = wsfd_pkg::EXT_BYTES_64;
          parse_phase = wsfd_pkg::PH_EXT;
        end else begin
          bytes_left = {57'd0, b[6:0]};
          if (masked_frame) begin
            hdr_left    = wsfd_pkg::KEY_BYTES;
            parse_phase = wsfd_pkg::PH_KEY;
          end else begin
            hdr_left = '0;
            close_header();
          end
        end
      end
      wsfd_pkg::PH_EXT: begin
        bytes_left = {bytes_left[55:0], b};
        hdr_left   = hdr_left - 4'd1;
        if (hdr_left == 4'd0) begin
          if (masked_frame) begin
            hdr_left    = wsfd_pkg::KEY_BYTES;
            parse_phase = wsfd_pkg::PH_KEY;
          end else begin
            close_header();
          end
        end
      end
      wsfd_pkg::PH_KEY: begin
        key_word = {key_word[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 4'd0) close_header();
      end
      wsfd_pkg::PH_DATA: begin
        kb         = 8'(key_word >> (24 - 8 * key_pos));
        key_pos    = key_pos + 2'd1;
        bytes_left = bytes_left - 64'd1;
        r.data     = b ^ kb;
        r.present  = 1'b1;
        r.last     = (bytes_left == 64'd0);
        r.fin      = fin_bit;
        r.opcode   = opcode_nib;
        add_expected(r);
        if (bytes_left == 64'd0) parse_phase = wsfd_pkg::PH_HDR0;
      end
      default: parse_phase = wsfd_pkg::PH_HDR0;
    endcase
  endfunction

  // payload_n is the number of payload bytes actually sent; it equals len
  // except for the oversized frame that ends the run.
  task automatic queue_frame(input len_form_t form, input logic [63:0] len,
                             input bit masked, input int unsigned payload_n);
    logic [31:0] key;
    key = $urandom;
    add_wire_byte(8'($urandom_range(0, 255)));
    case (form)
      LEN_SHORT: add_wire_byte({masked, len[6:0]});
      LEN_EXT16: begin
        add_wire_byte({masked, wsfd_pkg::LEN_CODE_16});
        add_wire_byte(len[15:8]);
        add_wire_byte(len[7:0]);
      end
      default: begin
        add_wire_byte({masked, wsfd_pkg::LEN_CODE_64});
        for (int i = 7; i >= 0; i--) add_wire_byte(len[8*i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) add_wire_byte(key[8*i +: 8]);
    end
    repeat (payload_n) add_wire_byte(8'($urandom_range(0, 255)));
    frames_built++;
  endtask

  // Request side: advance on each accepted byte, hold while stalled.
  always @(posedge clk) begin
    logic       next_valid;
    logic [7:0] next_data;
    bit         calm;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      parse_phase   = wsfd_pkg::PH_HDR0;
      hdr_left      = '0;
      bytes_left    = '0;
      key_word      = '0;
      key_pos       = '0;
      masked_frame  = 1'b0;
      fin_bit       = 1'b0;
      opcode_nib    = '0;
    end else begin
      calm = wire_bytes.size() < 100;
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        bytes_accepted++;
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        next_valid = 1'b0;
        next_data  = s_axis_tdata;
        if (src_gap > 0) begin
          src_gap--;
        end else if (!calm && !cycle_count[8] && $urandom_range(0, 7) == 0) begin
          src_gap = $urandom_range(1, 14) - 1;
        end else if (wire_bytes.size() > 0) begin
          next_valid = 1'b1;
          next_data  = wire_bytes.pop_front();
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= next_data;
      end
    end
  end

  // Result side: check each result, then pick the next ready.
  always @(posedge clk) begin
    deframed_t got;
    deframed_t want;
    logic      next_ready;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.data    = m_axis_tdata;
        got.present = m_axis_tuser[0];
        got.last    = m_axis_tlast;
        got.fin     = m_axis_tuser[1];
        got.opcode  = m_axis_tuser[5:2];
        results_seen++;
        if (deframed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result data=%h present=%b last=%b fin=%b op=%h",
                     $realtime, got.data, got.present, got.last, got.fin, got.opcode);
        end else begin
          want = deframed_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: result mismatch, expected data=%h present=%b last=%b ",
                        "fin=%b op=%h, got data=%h present=%b last=%b fin=%b op=%h"},
                       $realtime, want.data, want.present, want.last, want.fin,
                       want.opcode, got.data, got.present, got.last, got.fin, got.opcode);
          end
        end
      end
      next_ready = 1'b1;
      if (sink_gap > 0) begin
        sink_gap--;
        next_ready = 1'b0;
      end else if (wire_bytes.size() >= 100 && !cycle_count[8] &&
                   $urandom_range(0, 5) == 0) begin
        sink_gap   = $urandom_range(1, 14) - 1;
        next_ready = 1'b0;
      end
      m_axis_tready <= next_ready && !hold_off;
    end
  end

  // Long output hold-off while bytes keep coming, to back up the block.
  initial begin
    hold_off = 1'b0;
    while (bytes_accepted < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]  directed[21];
    int unsigned pick;
    int unsigned len;
    bit          masked;
    rst = 1'b1;

    // empty unmasked; empty masked with opcode 0xF; 16-bit length of zero
    // with RSV bits set; masked three-byte payload with extreme data values
    directed = '{8'h81, 8'h00,
                 8'h0F, 8'h80, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
                 8'h72, 8'h7E, 8'h00, 8'h00,
                 8'h82, 8'h83, 8'hFF, 8'h00, 8'h5A, 8'hA5, 8'hFF, 8'h00, 8'hA5};
    foreach (directed[i]) add_wire_byte(directed[i]);
    frames_built = 4;
    queue_frame(LEN_EXT64, 64'd0, 1'b0, 0);
    queue_frame(LEN_SHORT, 64'd125, 1'b1, 125);

    while (wire_bytes.size() < TARGET_BYTES) begin
      pick   = $urandom_range(0, 99);
      masked = $urandom_range(0, 2) != 0;
      if (pick < 55) begin
        len = $urandom_range(0, 12);
        queue_frame(LEN_SHORT, 64'(len), masked, len);
      end else if (pick < 60) begin
        len = $urandom_range(113, 125);
        queue_frame(LEN_SHORT, 64'(len), masked, len);
      end else if (pick < 80) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 24);
        queue_frame(LEN_EXT16, 64'(len), masked, len);
      end else if (pick < 95) begin
        len = $urandom_range(0, 16);
        queue_frame(LEN_EXT64, 64'(len), masked, len);
      end else begin
        queue_frame(LEN_SHORT, 64'd0, masked, 0);
      end
    end
    // Oversized frame with the top length bit set: payload flows, no end.
    queue_frame(LEN_EXT64, {1'b1, 31'($urandom), $urandom}, 1'b1, 24);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (wire_bytes.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (deframed_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d frames as %0d bytes through random gaps and output stalls",
             frames_built, bytes_accepted);
    $display("checked %0d results, %0d of them empty-frame markers; %0d mismatches",
             results_seen, markers_predicted, mismatches);
    if (mismatches == 0 && deframed_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
